// ===== src/p25tsbk_pkg.sv =====
`default_nettype none

package p25tsbk_pkg;

  localparam int DIBITS_PER_WORD_DEF = 32;
  localparam int OUT_WORD_BITS = 64;
  localparam int COUNT_BITS = 6;
  localparam int NAC_BITS = 12;

  localparam int FRAME_DIBITS = 180;
  localparam int FRAME_BITS = 2 * FRAME_DIBITS;
  localparam int RAW_DIBITS = 154;
  localparam int SYNC_DIBITS = 24;
  localparam int NID_DIBITS = 32;
  localparam int DATA_START = SYNC_DIBITS + NID_DIBITS;
  localparam int STATUS_PERIOD = 35;

  localparam int MSG_BITS = 80;
  localparam int BLOCK_BITS = 96;
  localparam int BLOCK_DIBITS = 48;
  localparam int ENC_PAIRS = 49;
  localparam int INTERLEAVE_GROUPS = 4;
  localparam int INTERLEAVE_ROWS = 13;

  localparam int FIFO_DEPTH = 2;

  localparam logic [47:0] FRAME_SYNC = 48'h5575F5FF77FF;
  localparam logic [3:0] DUID_TSBK = 4'h7;
  localparam logic [1:0] STATUS_DIBIT = 2'h2;
  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [15:0] CRC_INVERT = 16'hFFFF;

  typedef logic [63:0] nid_rows_t [16];
  localparam nid_rows_t NID_ROWS = '{
    64'h8000cd930bdd3b2a, 64'h4000ab5a8e33a6be,
    64'h2000983e4cc4e874, 64'h10004c1f2662743a,
    64'h0800eb9c98ec0136, 64'h0400b85d47ab3bb0,
    64'h02005c2ea3d59dd8, 64'h01002e1751eaceec,
    64'h0080170ba8f56776, 64'h0040c616dfa78890,
    64'h0020630b6fd3c448, 64'h00103185b7e9e224,
    64'h000818c2dbf4f112, 64'h0004c1f2662743a2,
    64'h0002ad6a38ce9afb, 64'h00019b2617ba7657
  };

  // entry is {first output dibit, second output dibit}, indexed [state][input]
  typedef logic [3:0] trellis_t [4][4];
  localparam trellis_t TRELLIS = '{
    '{4'h2, 4'hC, 4'h1, 4'hF},
    '{4'hE, 4'h0, 4'hD, 4'h3},
    '{4'h9, 4'h7, 4'hA, 4'h4},
    '{4'h5, 4'hB, 4'h6, 4'h8}
  };

  typedef struct packed {
    logic [15:0] header;
    logic [63:0] arguments;
    logic [15:0] crc;
  } block_t;

  typedef logic [FRAME_BITS-1:0] frame_t;
  typedef logic [MSG_BITS-1:0][15:0] crc_cols_t;

  // crc contribution of each message bit, first bit at index 0
  function automatic crc_cols_t crc_columns();
    crc_cols_t cols;
    logic [15:0] c;
    for (int i = 0; i < MSG_BITS; i++) begin
      c = CRC_POLY;
      for (int s = 0; s < MSG_BITS - 1 - i; s++) begin
        c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
      end
      cols[i] = c;
    end
    return cols;
  endfunction

  localparam crc_cols_t CRC_COLS = crc_columns();

  function automatic logic [15:0] crc_of(input logic [MSG_BITS-1:0] msg);
    logic [15:0] crc;
    crc = '0;
    for (int i = 0; i < MSG_BITS; i++) begin
      if (msg[MSG_BITS-1-i]) begin
        crc = crc ^ CRC_COLS[i];
      end
    end
    return crc ^ CRC_INVERT;
  endfunction

  function automatic logic [63:0] nid_of(input logic [NAC_BITS-1:0] nac);
    logic [15:0] d;
    logic [63:0] nid;
    d = {nac, DUID_TSBK};
    nid = '0;
    for (int i = 0; i < 16; i++) begin
      if (d[15-i]) begin
        nid = nid ^ NID_ROWS[i];
      end
    end
    return nid;
  endfunction

  function automatic frame_t build_frame(input block_t blk, input logic [63:0] nid);
    logic [BLOCK_BITS+1:0] bits;
    logic [1:0] raw [RAW_DIBITS];
    logic [3:0] enc [ENC_PAIRS];
    logic [1:0] prev;
    logic [1:0] d;
    frame_t fr;
    int p;
    int m;
    int f;
    int c;
    // block dibits plus the flush dibit
    bits = {blk, 2'b00};
    prev = 2'd0;
    for (int k = 0; k < ENC_PAIRS; k++) begin
      d = bits[BLOCK_BITS+1-2*k -: 2];
      enc[k] = TRELLIS[prev][d];
      prev = d;
    end
    for (int k = 0; k < SYNC_DIBITS; k++) begin
      raw[k] = FRAME_SYNC[47-2*k -: 2];
    end
    for (int k = 0; k < NID_DIBITS; k++) begin
      raw[SYNC_DIBITS+k] = nid[63-2*k -: 2];
    end
    // interleave: every fourth coded pair, offsets 0, 1, 2, 3
    p = DATA_START;
    for (int g = 0; g < INTERLEAVE_GROUPS; g++) begin
      for (int r = 0; r < INTERLEAVE_ROWS; r++) begin
        m = INTERLEAVE_GROUPS * r + g;
        if (m < ENC_PAIRS) begin
          raw[p] = enc[m][3:2];
          raw[p+1] = enc[m][1:0];
          p = p + 2;
        end
      end
    end
    // status after every 35 dibits, zero pad, closing status
    fr = '0;
    f = 0;
    c = 0;
    for (int k = 0; k < RAW_DIBITS; k++) begin
      fr[FRAME_BITS-1-2*f -: 2] = raw[k];
      f = f + 1;
      c = c + 1;
      if (c == STATUS_PERIOD) begin
        fr[FRAME_BITS-1-2*f -: 2] = STATUS_DIBIT;
        f = f + 1;
        c = 0;
      end
    end
    fr[1:0] = STATUS_DIBIT;
    return fr;
  endfunction

endpackage

`default_nettype wire

// ===== src/p25tsbk_if.sv =====
`default_nettype none

interface p25tsbk_in_if;
  logic        valid;
  logic        ready;
  logic        last_tsbk;
  logic [6:0]  opcode;
  logic [7:0]  manufacturer_id;
  logic [63:0] arguments;

  modport source (output valid, last_tsbk, opcode, manufacturer_id, arguments, input ready);
  modport sink (input valid, last_tsbk, opcode, manufacturer_id, arguments, output ready);
endinterface

interface p25tsbk_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] dibit_word;
  logic [5:0]  dibit_count;
  logic        frame_end;

  modport source (output valid, dibit_word, dibit_count, frame_end, input ready);
  modport sink (input valid, dibit_word, dibit_count, frame_end, output ready);
endinterface

interface p25tsbk_cfg_if;
  logic        valid;
  logic        ready;
  logic [11:0] network_access_code;

  modport source (output valid, network_access_code, input ready);
  modport sink (input valid, network_access_code, output ready);
endinterface

`default_nettype wire

// ===== src/p25tsbk_front.sv =====
`default_nettype none

module p25tsbk_front (
  p25tsbk_in_if.sink           tsbk,
  output logic                 push_valid,
  input  logic                 push_ready,
  output p25tsbk_pkg::block_t  push_data
);

  logic [15:0] header;

  assign header = {tsbk.last_tsbk, tsbk.opcode, tsbk.manufacturer_id};

  assign push_data.header    = header;
  assign push_data.arguments = tsbk.arguments;
  assign push_data.crc       = p25tsbk_pkg::crc_of({header, tsbk.arguments});

  assign push_valid = tsbk.valid;
  assign tsbk.ready = push_ready;

endmodule

`default_nettype wire

// ===== src/p25tsbk_fifo.sv =====
`default_nettype none

module p25tsbk_fifo (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push_valid,
  output logic                 push_ready,
  input  p25tsbk_pkg::block_t  push_data,
  output logic                 pop_valid,
  input  logic                 pop_ready,
  output p25tsbk_pkg::block_t  pop_data
);

  localparam int DEPTH = p25tsbk_pkg::FIFO_DEPTH;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  p25tsbk_pkg::block_t entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic push;
  logic pop;

  assign push_ready = count != CNT_W'(DEPTH);
  assign pop_valid  = count != '0;
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_data   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/p25tsbk_back.sv =====
`default_nettype none

module p25tsbk_back #(
  parameter int DIBITS_PER_WORD = p25tsbk_pkg::DIBITS_PER_WORD_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  p25tsbk_cfg_if.sink          cfg,
  input  logic                 pop_valid,
  output logic                 pop_ready,
  input  p25tsbk_pkg::block_t  pop_data,
  p25tsbk_out_if.source        dibits
);

  localparam int WORD_BITS  = 2 * DIBITS_PER_WORD;
  localparam int FRAME_BITS = p25tsbk_pkg::FRAME_BITS;
  localparam int OUT_BITS   = p25tsbk_pkg::OUT_WORD_BITS;
  localparam int REM_W      = $clog2(p25tsbk_pkg::FRAME_DIBITS + 1);
  localparam logic [REM_W-1:0] WORD_DIBITS = REM_W'(DIBITS_PER_WORD);
  localparam logic [REM_W-1:0] FRAME_LEN   = REM_W'(p25tsbk_pkg::FRAME_DIBITS);

  logic [p25tsbk_pkg::NAC_BITS-1:0] nac;
  p25tsbk_pkg::frame_t frame_sr;
  p25tsbk_pkg::frame_t frame_sr_next;
  logic [REM_W-1:0] remaining;
  logic [REM_W-1:0] remaining_next;
  logic [REM_W-1:0] take;
  logic advance;
  logic last_word;
  logic emit;
  logic load;

  logic        out_valid;
  logic [63:0] word_q;
  logic [5:0]  count_q;
  logic        end_q;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      nac <= '0;
    end else if (cfg.valid) begin
      nac <= cfg.network_access_code;
    end
  end

  // output register frees when empty or taken
  assign advance   = !out_valid || dibits.ready;
  assign last_word = remaining <= WORD_DIBITS;
  assign emit      = advance && (remaining != '0);
  assign pop_ready = (remaining == '0) || (emit && last_word);
  assign load      = pop_valid && pop_ready;
  assign take      = last_word ? remaining : WORD_DIBITS;

  always_comb begin
    frame_sr_next  = frame_sr;
    remaining_next = remaining;
    if (load) begin
      frame_sr_next  = p25tsbk_pkg::build_frame(pop_data, p25tsbk_pkg::nid_of(nac));
      remaining_next = FRAME_LEN;
    end else if (emit) begin
      frame_sr_next  = frame_sr << WORD_BITS;
      remaining_next = remaining - take;
    end
  end

  always_ff @(posedge clk) begin
    frame_sr <= frame_sr_next;
    if (emit) begin
      word_q  <= OUT_BITS'(frame_sr[FRAME_BITS-1 -: WORD_BITS]) << (OUT_BITS - WORD_BITS);
      count_q <= p25tsbk_pkg::COUNT_BITS'(take);
      end_q   <= last_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      remaining <= '0;
      out_valid <= 1'b0;
    end else begin
      remaining <= remaining_next;
      if (advance) begin
        out_valid <= emit;
      end
    end
  end

  assign dibits.valid       = out_valid;
  assign dibits.dibit_word  = word_q;
  assign dibits.dibit_count = count_q;
  assign dibits.frame_end   = end_q;

endmodule

`default_nettype wire

// ===== src/p25_tsbk_frame_encoder.sv =====
// p25_tsbk_frame_encoder: turns one trunking signalling block into a 180-dibit frame
// channels
//   tsbk   - sink: last_tsbk, opcode, manufacturer_id, arguments, one block per transaction
//   dibits - source: dibit_word, dibit_count, frame_end, one packed word per transaction
//   cfg    - sink: network_access_code, always ready, write only while the block is idle
// a block gives ceil(180 / DIBITS_PER_WORD) words; with 32 dibits per word that is
// five words of 32 dibits and a final word of 20, frame_end on the last
// an accepted block loads the frame shift register; each word is then registered for output
// throughput: one word per cycle while the receiver takes words, no gap between frames;
// the output word register sets that rate, the frame shift register moves one word a cycle
// a two-entry block queue sits between the crc front end and the frame back end, so
// blocks are taken while earlier frames still leave; tsbk.ready drops when it is full
// receiver stall: the current word holds, the frame pauses, the queue fills
// reset empties the queue and the frame, clears output valid and network_access_code to 0
`default_nettype none

module p25_tsbk_frame_encoder #(
  parameter int DIBITS_PER_WORD = p25tsbk_pkg::DIBITS_PER_WORD_DEF
) (
  input  logic           clk,
  input  logic           rst,
  p25tsbk_in_if.sink     tsbk,
  p25tsbk_out_if.source  dibits,
  p25tsbk_cfg_if.sink    cfg
);

  logic                push_valid;
  logic                push_ready;
  p25tsbk_pkg::block_t push_data;
  logic                pop_valid;
  logic                pop_ready;
  p25tsbk_pkg::block_t pop_data;

  p25tsbk_front u_front (
    .tsbk       (tsbk),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  p25tsbk_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  p25tsbk_back #(
    .DIBITS_PER_WORD (DIBITS_PER_WORD)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .dibits    (dibits)
  );

endmodule

`default_nettype wire

// ===== src/p25tsbk_checker.sv =====
`default_nettype none

module p25tsbk_checker #(
  parameter int DIBITS_PER_WORD = p25tsbk_pkg::DIBITS_PER_WORD_DEF
) (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [63:0] dibit_word,
  input logic [5:0]  dibit_count,
  input logic        frame_end
);

  localparam int WORDS =
    (p25tsbk_pkg::FRAME_DIBITS + DIBITS_PER_WORD - 1) / DIBITS_PER_WORD;
  localparam int LAST_COUNT = p25tsbk_pkg::FRAME_DIBITS - (WORDS - 1) * DIBITS_PER_WORD;

  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid right after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(dibit_word) &&
      $stable(dibit_count) && $stable(frame_end))
    else $error("stalled word changed");

  a_full_word: assert property (@(posedge clk) disable iff (rst)
    out_valid && !frame_end |-> dibit_count == 6'(DIBITS_PER_WORD))
    else $error("short word before frame end");

  a_last_word: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_end |-> dibit_count == 6'(LAST_COUNT))
    else $error("wrong dibit count on last word");

  a_zero_tail: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (dibit_word << {dibit_count, 1'b0}) == 64'd0)
    else $error("bits below last valid dibit not zero");

endmodule

bind p25_tsbk_frame_encoder p25tsbk_checker #(
  .DIBITS_PER_WORD (DIBITS_PER_WORD)
) u_p25tsbk_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (dibits.valid),
  .out_ready   (dibits.ready),
  .dibit_word  (dibits.dibit_word),
  .dibit_count (dibits.dibit_count),
  .frame_end   (dibits.frame_end)
);

`default_nettype wire
